/* hw/rtl/iods_pkg.sv */
// Package for the I/O device request scheduler.
// Holds shared types, result codes and sizes; no dependencies.
package iods_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_DEV = 3;

  typedef enum logic [2:0] {
    KIND_STARTED  = 3'd0,
    KIND_QUEUED   = 3'd1,
    KIND_NO_DEV   = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_DONE     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CFG_KBD  = 2'd0,
    CFG_DISK = 2'd1,
    CFG_NET  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        action;
    logic [15:0] pid;
    logic [1:0]  device_type;
    logic [15:0] tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] request_id;
    logic [15:0] owner_pid;
    logic [1:0]  device_id;
    logic [15:0] label;
    logic        last;
  } out_item_t;

  // One waiting or running request.
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pid;
    logic [15:0] tag;
    logic [1:0]  dev;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REQ,
    ST_TICK,
    ST_EMIT,
    ST_SCAN,
    ST_SHIFT
  } state_t;

endpackage

/* hw/rtl/iods_stream_if.sv */
// Valid/ready stream interface carrying one payload.
// Depends on no other file; the payload type is a type parameter.
interface iods_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/io_device_request_scheduler.sv */
// Top level of the I/O device request scheduler.
// Depends on iods_pkg, iods_stream_if, iods_front and iods_back.
//
// A request is taken by the back end and yields one result. A tick is taken,
// counts down the running devices and emits its completions in start order,
// one per cycle, each waiting for the output to drain. Then each device in
// turn is visited, scanning or shifting queue entries when it is idle, and
// a final scan step ends the tick. A two-entry queue in front lets new
// requests arrive while a tick runs.
module io_device_request_scheduler import iods_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  iods_stream_if.sink   in_if,
  iods_stream_if.source out_if,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_data
);

  logic [7:0] lat_r [NUM_DEV];
  logic q_valid, q_ready;
  in_item_t q_data;

  // Latency registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r[0] <= 8'd2;
      lat_r[1] <= 8'd5;
      lat_r[2] <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_KBD:  lat_r[0] <= cfg_data;
        CFG_DISK: lat_r[1] <= cfg_data;
        CFG_NET:  lat_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  iods_front u_front (
    .clk, .rst_n,
    .in_valid(in_if.valid), .in_ready(in_if.ready), .in_data(in_if.data),
    .q_valid, .q_ready, .q_data
  );

  iods_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .lat(lat_r),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
  );

endmodule

/* hw/rtl/iods_front.sv */
// Front end: accepts requests into a two-entry queue for the back end.
// Depends on iods_pkg.
module iods_front import iods_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output in_item_t q_data
);

  in_item_t  buf_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rp_r];

  // Two-entry FIFO between input and scheduler core.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        buf_r[wp_r] <= in_data;
        wp_r <= ~wp_r;
      end
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end

endmodule

/* hw/rtl/iods_back.sv */
// Back end: device state, waiting queue and result generation.
// Depends on iods_pkg.
module iods_back import iods_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  in_item_t  q_data,
  input  logic [7:0] lat [NUM_DEV],
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  state_t state_r, state_nxt;
  in_item_t item_r;
  logic [NUM_DEV-1:0] busy_r, done_r;
  logic [7:0] cd_r [NUM_DEV];
  logic [1:0] rank_r [NUM_DEV];
  req_t run_r [NUM_DEV];
  req_t wq_r [QUEUE_DEPTH];
  logic [CW-1:0] wcnt_r;
  logic [15:0] nid_r;
  logic [1:0] dev_r, emr_r;
  logic [CW-1:0] idx_r;
  logic ov_r;
  out_item_t od_r;

  assign q_ready = (state_r == ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data = od_r;

  function automatic logic [1:0] cnt_busy(input logic [NUM_DEV-1:0] b);
    return 2'(b[0]) + 2'(b[1]) + 2'(b[2]);
  endfunction

  // Completion of rank emr_r, and whether any of higher rank remain after it.
  logic [1:0] emit_dev;
  logic emit_hit, more_after;
  always_comb begin
    emit_dev = 2'd0;
    emit_hit = 1'b0;
    more_after = 1'b0;
    for (int d = 0; d < NUM_DEV; d++) begin
      if (done_r[d] && rank_r[d] == emr_r) begin
        emit_hit = 1'b1;
        emit_dev = 2'(d);
      end
      if (done_r[d] && rank_r[d] > emr_r) more_after = 1'b1;
    end
  end

  // A result is loaded when a request is handled or a completion goes out.
  logic ov_set;
  assign ov_set = (state_r == ST_REQ) ||
                  (state_r == ST_EMIT && (!ov_r || out_ready) && emit_hit);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (q_valid && q_ready) state_nxt = q_data.action ? ST_TICK : ST_REQ;
      ST_REQ:   state_nxt = ST_IDLE;
      ST_TICK:  state_nxt = ST_EMIT;
      ST_EMIT:  if (!ov_r || out_ready) begin
                  if (!(emit_hit && more_after) && !(!emit_hit && emr_r != 2'd3))
                    state_nxt = ST_SCAN;
                end
      ST_SCAN:  if (dev_r == 2'(NUM_DEV)) state_nxt = ST_IDLE;
                else if (busy_r[dev_r] || idx_r == wcnt_r) ;
                else if (wq_r[idx_r[QW-1:0]].dev == dev_r) state_nxt = ST_SHIFT;
      ST_SHIFT: if (idx_r + CW'(1) >= wcnt_r) state_nxt = ST_SCAN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r <= '0;
      done_r <= '0;
      wcnt_r <= '0;
      nid_r <= 16'd1;
      ov_r <= 1'b0;
      emr_r <= '0;
      dev_r <= '0;
      idx_r <= '0;
      for (int d = 0; d < NUM_DEV; d++) begin
        cd_r[d] <= '0;
        rank_r[d] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (ov_set) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (q_valid && q_ready) item_r <= q_data;
        // A request: start, queue or reject.
        ST_REQ: begin
          od_r.owner_pid <= item_r.pid;
          od_r.label <= item_r.tag;
          od_r.last <= 1'b1;
          if (item_r.device_type == 2'd3) begin
            od_r.kind <= KIND_NO_DEV;
            od_r.request_id <= '0;
            od_r.device_id <= '0;
          end else if (busy_r[item_r.device_type] && wcnt_r == CW'(QUEUE_DEPTH)) begin
            od_r.kind <= KIND_FULL;
            od_r.request_id <= '0;
            od_r.device_id <= item_r.device_type + 2'd1;
          end else begin
            od_r.request_id <= nid_r;
            od_r.device_id <= item_r.device_type + 2'd1;
            nid_r <= (nid_r == 16'hFFFF) ? 16'd1 : nid_r + 16'd1;
            if (busy_r[item_r.device_type]) begin
              od_r.kind <= KIND_QUEUED;
              wq_r[wcnt_r[QW-1:0]] <= '{nid_r, item_r.pid, item_r.tag,
                                         item_r.device_type};
              wcnt_r <= wcnt_r + CW'(1);
            end else begin
              od_r.kind <= KIND_STARTED;
              busy_r[item_r.device_type] <= 1'b1;
              run_r[item_r.device_type] <= '{nid_r, item_r.pid, item_r.tag,
                                             item_r.device_type};
              cd_r[item_r.device_type] <= (lat[item_r.device_type] == 8'd0) ? 8'd1
                                          : lat[item_r.device_type];
              rank_r[item_r.device_type] <= cnt_busy(busy_r);
            end
          end
        end
        // Decrement running countdowns and mark finished devices.
        ST_TICK: begin
          emr_r <= '0;
          for (int d = 0; d < NUM_DEV; d++) begin
            done_r[d] <= busy_r[d] && cd_r[d] <= 8'd1;
            if (busy_r[d] && cd_r[d] != 8'd0) cd_r[d] <= cd_r[d] - 8'd1;
          end
        end
        // Emit completions in rank order, then free devices and re-rank.
        ST_EMIT: if (!ov_r || out_ready) begin
          if (emit_hit) begin
            od_r <= '{KIND_DONE, run_r[emit_dev].id, run_r[emit_dev].pid,
                      emit_dev + 2'd1, run_r[emit_dev].tag, !more_after};
          end
          emr_r <= emr_r + 2'd1;
          if (state_nxt == ST_SCAN) begin
            busy_r <= busy_r & ~done_r;
            for (int d = 0; d < NUM_DEV; d++) begin
              logic [1:0] c;
              c = '0;
              for (int o = 0; o < NUM_DEV; o++)
                if (busy_r[o] && !done_r[o] && rank_r[o] < rank_r[d]) c = c + 2'd1;
              rank_r[d] <= (busy_r[d] && !done_r[d]) ? c : 2'd0;
            end
            dev_r <= '0;
            idx_r <= '0;
          end
        end
        // Find oldest waiting request for each idle device, one entry a cycle.
        ST_SCAN: if (dev_r != 2'(NUM_DEV)) begin
          if (busy_r[dev_r] || idx_r == wcnt_r) begin
            dev_r <= dev_r + 2'd1;
            idx_r <= '0;
          end else if (wq_r[idx_r[QW-1:0]].dev == dev_r) begin
            busy_r[dev_r] <= 1'b1;
            run_r[dev_r] <= wq_r[idx_r[QW-1:0]];
            cd_r[dev_r] <= (lat[dev_r] == 8'd0) ? 8'd1 : lat[dev_r];
            rank_r[dev_r] <= cnt_busy(busy_r);
          end else idx_r <= idx_r + CW'(1);
        end
        // Compact the queue over the removed entry.
        ST_SHIFT: begin
          if (idx_r + CW'(1) < wcnt_r) begin
            wq_r[idx_r[QW-1:0]] <= wq_r[QW'(idx_r + CW'(1))];
            idx_r <= idx_r + CW'(1);
          end else begin
            wcnt_r <= wcnt_r - CW'(1);
            dev_r <= dev_r + 2'd1;
            idx_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) wcnt_r <= CW'(QUEUE_DEPTH))
    else $error("queue count overflow");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> !ov_r && state_r == ST_IDLE) else $error("accept while busy");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && od_r.kind == KIND_DONE) |-> od_r.device_id != 2'd0)
    else $error("completion without device");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the I/O device request scheduler.
// Depends on iods_pkg, iods_stream_if and io_device_request_scheduler.
// A built-in predictor of the three devices and the shared queue checks every result.
module tb_top;
  import iods_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int DRAIN_CYCLES = 100;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_data;

  iods_stream_if #(.T(in_item_t))  in_ch ();
  iods_stream_if #(.T(out_item_t)) out_ch ();

  io_device_request_scheduler dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // Predictor state: devices, running requests and the shared waiting queue.
  logic [7:0]  lat_m [NUM_DEV];
  logic        busy_m [NUM_DEV];
  logic [7:0]  count_m [NUM_DEV];
  logic [1:0]  rank_m [NUM_DEV];
  req_t        running_m [NUM_DEV];
  req_t        waiting_m [$];
  logic [15:0] next_id_m;

  out_item_t   pending_results [$];
  int          errors;
  int          results_seen;
  int          n_requests;
  int          n_ticks;
  int          cycles;
  bit          quiet;
  bit          long_hold_req;

  // Clock and cycle limit.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL io_device_request_scheduler");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
  endtask

  // Starts a request on an idle device; rank counts the devices already busy.
  function automatic void start_device(input int d, input req_t r);
    int n;
    n = 0;
    for (int i = 0; i < NUM_DEV; i++) if (busy_m[i]) n++;
    busy_m[d] = 1'b1;
    running_m[d] = r;
    count_m[d] = (lat_m[d] == 8'd0) ? 8'd1 : lat_m[d];
    rank_m[d] = 2'(n);
  endfunction

  // Works out the results of one accepted item and updates the predictor.
  function automatic void predict_scheduler(input in_item_t it, ref out_item_t res [$]);
    out_item_t o;
    req_t      r;
    bit        done [NUM_DEV];
    logic [1:0] nr [NUM_DEV];
    int        c;
    res = {};
    if (!it.action) begin
      o = '0;
      o.owner_pid = it.pid;
      o.label = it.tag;
      o.last = 1'b1;
      if (it.device_type == 2'd3) begin
        o.kind = KIND_NO_DEV;
      end else if (busy_m[it.device_type] && waiting_m.size() >= QUEUE_DEPTH) begin
        o.kind = KIND_FULL;
        o.device_id = it.device_type + 2'd1;
      end else begin
        r.id = next_id_m;
        r.pid = it.pid;
        r.tag = it.tag;
        r.dev = it.device_type;
        if (next_id_m == 16'hffff) next_id_m = 16'd1;
        else next_id_m++;
        o.request_id = r.id;
        o.device_id = it.device_type + 2'd1;
        if (busy_m[it.device_type]) begin
          waiting_m = {waiting_m, r};
          o.kind = KIND_QUEUED;
        end else begin
          start_device(it.device_type, r);
          o.kind = KIND_STARTED;
        end
      end
      res = {res, o};
    end else begin
      for (int d = 0; d < NUM_DEV; d++) begin
        done[d] = 1'b0;
        if (busy_m[d] && count_m[d] > 0) count_m[d]--;
      end
      // Completions come out oldest start first.
      for (int k = 0; k < NUM_DEV; k++) begin
        for (int d = 0; d < NUM_DEV; d++) begin
          if (busy_m[d] && rank_m[d] == k && count_m[d] == 0 && !done[d]) begin
            done[d] = 1'b1;
            o = '0;
            o.kind = KIND_DONE;
            o.request_id = running_m[d].id;
            o.owner_pid = running_m[d].pid;
            o.device_id = 2'(d + 1);
            o.label = running_m[d].tag;
            res = {res, o};
          end
        end
      end
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
      for (int d = 0; d < NUM_DEV; d++) if (done[d]) busy_m[d] = 1'b0;
      for (int d = 0; d < NUM_DEV; d++) begin
        c = 0;
        if (busy_m[d])
          for (int e = 0; e < NUM_DEV; e++)
            if (busy_m[e] && rank_m[e] < rank_m[d]) c++;
        nr[d] = 2'(c);
      end
      for (int d = 0; d < NUM_DEV; d++) rank_m[d] = busy_m[d] ? nr[d] : 2'd0;
      // Each idle device takes its oldest waiting request.
      for (int d = 0; d < NUM_DEV; d++) begin
        if (!busy_m[d]) begin
          for (int i = 0; i < waiting_m.size(); i++) begin
            if (waiting_m[i].dev == d) begin
              r = waiting_m[i];
              waiting_m.delete(i);
              start_device(d, r);
              break;
            end
          end
        end
      end
    end
  endfunction

  // Result side: random ready with short and long gaps, plus a long hold on demand.
  int hold_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
    end else if (long_hold_req) begin
      out_ch.ready <= 1'b0;
      hold_left <= 400;
      long_hold_req <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (quiet || $urandom_range(0, 99) < 70) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end
  end

  // Compare every accepted result with the oldest pending one.
  always @(posedge clk) begin
    out_item_t g;
    out_item_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g = out_ch.data;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", g.kind, 0);
      end else begin
        w = pending_results.pop_front();
        if (g.kind != w.kind) report_mismatch("kind", g.kind, w.kind);
        if (g.request_id != w.request_id) report_mismatch("request_id", g.request_id, w.request_id);
        if (g.owner_pid != w.owner_pid) report_mismatch("owner_pid", g.owner_pid, w.owner_pid);
        if (g.device_id != w.device_id) report_mismatch("device_id", g.device_id, w.device_id);
        if (g.label != w.label) report_mismatch("label", g.label, w.label);
        if (g.last != w.last) report_mismatch("last", g.last, w.last);
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one request and waits for the handshake; typed results override the prediction.
  task automatic send_request(input in_item_t it, input bit typed, input out_item_t typed_res [$]);
    out_item_t res [$];
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_scheduler(it, res);
    if (typed) res = typed_res;
    foreach (res[i]) pending_results = {pending_results, res[i]};
    if (it.action) n_ticks++;
    else n_requests++;
  endtask

  task automatic send_plain(input in_item_t it);
    out_item_t none [$];
    send_request(it, 1'b0, none);
  endtask

  // Lets the block go idle by waiting until no result is pending.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_latency(input logic [1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx < NUM_DEV) lat_m[idx] = val;
  endtask

  function automatic in_item_t random_item(input int tick_pct);
    in_item_t it;
    it.action = ($urandom_range(0, 99) < tick_pct);
    it.pid = 16'($urandom);
    it.tag = 16'($urandom);
    it.device_type = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    return it;
  endfunction

  function automatic out_item_t mk(input kind_t k, input int id, input int pid,
                                   input int dev, input int tag);
    out_item_t o;
    o.kind = k;
    o.request_id = 16'(id);
    o.owner_pid = 16'(pid);
    o.device_id = 2'(dev);
    o.label = 16'(tag);
    o.last = 1'b1;
    return o;
  endfunction

  typedef struct {
    in_item_t  it;
    bit        typed;
    int        n_res;
    out_item_t res;
  } stim_row_t;

  stim_row_t directed [19];

  initial begin
    in_item_t it;
    out_item_t tr [$];
    int phase;
    logic [7:0] lat_set [4][3];
    errors = 0;
    results_seen = 0;
    n_requests = 0;
    n_ticks = 0;
    cycles = 0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_KBD;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    lat_m = '{8'd2, 8'd5, 8'd3};
    for (int d = 0; d < NUM_DEV; d++) begin
      busy_m[d] = 1'b0;
      count_m[d] = '0;
      rank_m[d] = '0;
      running_m[d] = '0;
    end
    next_id_m = 16'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset latencies; expected values typed where obvious.
    directed = '{
      '{'{1'b0, 16'hffff, 2'd0, 16'h0000}, 1, 1, mk(KIND_STARTED, 1, 'hffff, 1, 0)},
      '{'{1'b0, 16'h0000, 2'd1, 16'hffff}, 1, 1, mk(KIND_STARTED, 2, 0, 2, 'hffff)},
      '{'{1'b0, 16'h1234, 2'd2, 16'h5678}, 1, 1, mk(KIND_STARTED, 3, 'h1234, 3, 'h5678)},
      '{'{1'b0, 16'habcd, 2'd3, 16'h0001}, 1, 1, mk(KIND_NO_DEV, 0, 'habcd, 0, 1)},
      '{'{1'b0, 16'h0002, 2'd0, 16'h0002}, 1, 1, mk(KIND_QUEUED, 4, 2, 1, 2)},
      '{'{1'b1, 16'h0000, 2'd0, 16'h0000}, 1, 0, '0},
      '{'{1'b1, 16'hffff, 2'd3, 16'hffff}, 1, 1, mk(KIND_DONE, 1, 'hffff, 1, 0)},
      '{'{1'b0, 16'h5555, 2'd1, 16'haaaa}, 0, 0, '0},
      '{'{1'b0, 16'haaaa, 2'd2, 16'h5555}, 0, 0, '0},
      '{'{1'b0, 16'h0003, 2'd0, 16'h0003}, 0, 0, '0},
      '{'{1'b1, 16'h0000, 2'd0, 16'h0000}, 0, 0, '0},
      '{'{1'b1, 16'h0000, 2'd0, 16'h0000}, 0, 0, '0},
      '{'{1'b1, 16'h0000, 2'd0, 16'h0000}, 0, 0, '0},
      '{'{1'b0, 16'h8000, 2'd3, 16'h8000}, 0, 0, '0},
      '{'{1'b1, 16'h0000, 2'd0, 16'h0000}, 0, 0, '0},
      '{'{1'b1, 16'h0000, 2'd0, 16'h0000}, 0, 0, '0},
      '{'{1'b1, 16'h0000, 2'd0, 16'h0000}, 0, 0, '0},
      '{'{1'b1, 16'h0000, 2'd0, 16'h0000}, 0, 0, '0},
      '{'{1'b1, 16'h0000, 2'd0, 16'h0000}, 0, 0, '0}
    };
    foreach (directed[i]) begin
      tr = {};
      if (directed[i].n_res > 0) tr = {tr, directed[i].res};
      send_request(directed[i].it, directed[i].typed, tr);
    end

    // Latency settings per phase, extremes included; index 3 is out of range.
    lat_set = '{'{8'd0, 8'd1, 8'd255}, '{8'd255, 8'd0, 8'd7},
                '{8'd1, 8'd1, 8'd1}, '{8'd3, 8'd9, 8'd2}};
    for (phase = 0; phase < 5; phase++) begin
      wait_quiet();
      if (phase < 4) begin
        write_latency(CFG_KBD, lat_set[phase][0]);
        write_latency(CFG_DISK, lat_set[phase][1]);
        write_latency(CFG_NET, lat_set[phase][2]);
      end else begin
        write_latency(2'd3, 8'($urandom));
        for (int d = 0; d < NUM_DEV; d++) write_latency(2'(d), 8'($urandom_range(0, 12)));
      end
      for (int n = 0; n < 60; n++) begin
        if (n % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
        // Mostly requests so the shared queue fills and overflows.
        it = random_item((n < 30) ? 20 : 45);
        if (phase == 1 && n == 10) long_hold_req <= 1'b1;
        send_plain(it);
      end
      quiet = 1'b0;
    end

    wait_quiet();
    $display("covered %0d requests and %0d ticks over six latency settings, long output stall included",
             n_requests, n_ticks);
    $display("%0d results checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("PASS io_device_request_scheduler");
    end else begin
      $display("FAIL io_device_request_scheduler");
    end
    $finish;
  end

  // A result still pending when time runs out is caught by the cycle limit.
endmodule
